// ----- rtl/sorted_table_engine_core_assert.svh -----
// Assertion macros used by the sorted table engine controller.
`ifndef SORTED_TABLE_ENGINE_CORE_ASSERT_SVH
`define SORTED_TABLE_ENGINE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define STE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted table engine: check failed");
// next-cycle implication
`define STE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted table engine: check failed");
`else
`define STE_ASSERT_NOW(label, clk, rst, ante, cons)
`define STE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/ste_pkg.sv -----
package ste_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   // command broadcast from the controller to every cell
   typedef struct packed {
      logic capture;   // latch compare flags against the incoming value
      logic insert;    // open a slot at the insertion point, shift up
      logic remove;    // close the slot of the first match, shift down
   } cell_cmd_type;

endpackage

// ----- rtl/sorted_table_engine_core.sv -----
// Channel | Dir | tdata (low bit up)                               | tuser
// req     | in  | item_value                                       | opcode
// rsp     | out | status, found, entry_total, empty_flag, full_flag | -
//
// For each request the cell row latches its compare flags on the transfer,
// then applies the shift and loads the result register.
// A new request is not taken until the current one has been applied.
// A stalled result holds the update and keeps req_tready low until it drains.
// Reset (synchronous, active high) empties the table at once.
module sorted_table_engine_core #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32,
   localparam int CNT_BITS      = $clog2(CAPACITY + 1),
   localparam int REQ_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8,
   localparam int RSP_FIELDS    = CNT_BITS + 5,
   localparam int RSP_DATA_BITS = ((RSP_FIELDS + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,   // item_value
   input  logic [1:0]                req_tuser,   // opcode
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // status[1:0], found, entry_total, empty_flag, full_flag
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata
);

   ste_pkg::cell_cmd_type   cmd;
   logic [VALUE_BITS-1:0]   key;
   logic [VALUE_BITS-1:0]   req_value;
   logic [CNT_BITS-1:0]     count;
   logic [VALUE_BITS-1:0]   cell_value [CAPACITY];
   logic [CAPACITY-1:0]     cell_lt;
   logic [CAPACITY-1:0]     cell_eq;
   logic                    hit;
   logic [1:0]              rsp_status;
   logic                    rsp_found;
   logic [CNT_BITS-1:0]     rsp_total;
   logic                    rsp_empty;
   logic                    rsp_full;

   assign req_value = req_tdata[VALUE_BITS-1:0];
   assign hit       = |cell_eq;

   ste_ctrl #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS),
      .CNT_BITS   (CNT_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser),
      .req_value  (req_value),
      .hit        (hit),
      .cmd        (cmd),
      .key        (key),
      .count      (count),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_found  (rsp_found),
      .rsp_total  (rsp_total),
      .rsp_empty  (rsp_empty),
      .rsp_full   (rsp_full)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_BITS-1:0] prev_value;
      logic                  prev_lt;
      logic [VALUE_BITS-1:0] next_value;

      // the slot before the head counts as below every key
      if (i == 0) begin : g_head
         assign prev_value = key;
         assign prev_lt    = 1'b1;
      end else begin : g_body
         assign prev_value = cell_value[i-1];
         assign prev_lt    = cell_lt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_value = key;
      end else begin : g_inner
         assign next_value = cell_value[i+1];
      end

      ste_cell #(
         .VALUE_BITS (VALUE_BITS),
         .CNT_BITS   (CNT_BITS),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count),
         .cmp_key    (req_value),
         .ins_key    (key),
         .prev_value (prev_value),
         .prev_lt    (prev_lt),
         .next_value (next_value),
         .value      (cell_value[i]),
         .lt         (cell_lt[i]),
         .eq         (cell_eq[i])
      );
   end

   assign rsp_tdata = RSP_DATA_BITS'({rsp_full, rsp_empty, rsp_total, rsp_found, rsp_status});

endmodule

// ----- rtl/ste_cell.sv -----
module ste_cell #(
   parameter int VALUE_BITS = 32,
   parameter int CNT_BITS   = 5,
   parameter int INDEX      = 0
) (
   input  logic                    clock,
   input  ste_pkg::cell_cmd_type   cmd,
   input  logic [CNT_BITS-1:0]     count,
   input  logic [VALUE_BITS-1:0]   cmp_key,
   input  logic [VALUE_BITS-1:0]   ins_key,
   input  logic [VALUE_BITS-1:0]   prev_value,
   input  logic                    prev_lt,
   input  logic [VALUE_BITS-1:0]   next_value,
   output logic [VALUE_BITS-1:0]   value,
   output logic                    lt,
   output logic                    eq
);

   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  lt_ff, lt_in;
   logic                  eq_ff, eq_in;
   logic                  occupied;

   assign occupied = count > CNT_BITS'(INDEX);

   always_comb begin
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (cmd.capture) begin
         lt_in = occupied && ($signed(value_ff) < $signed(cmp_key));
         eq_in = occupied && (value_ff == cmp_key);
      end
   end

   // on insert, entries below the key stay; the first slot not below takes the key
   always_comb begin
      value_in = value_ff;
      if (cmd.insert && !lt_ff) begin
         value_in = prev_lt ? ins_key : prev_value;
      end else if (cmd.remove && !lt_ff) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign value = value_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

// ----- rtl/ste_ctrl.sv -----
`include "sorted_table_engine_core_assert.svh"

module ste_ctrl #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32,
   parameter int CNT_BITS   = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [1:0]              req_opcode,
   input  logic [VALUE_BITS-1:0]   req_value,
   input  logic                    hit,
   output ste_pkg::cell_cmd_type   cmd,
   output logic [VALUE_BITS-1:0]   key,
   output logic [CNT_BITS-1:0]     count,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [1:0]              rsp_status,
   output logic                    rsp_found,
   output logic [CNT_BITS-1:0]     rsp_total,
   output logic                    rsp_empty,
   output logic                    rsp_full
);

   logic                    busy_ff, busy_in;
   ste_pkg::op_type         op_ff, op_in;
   logic [VALUE_BITS-1:0]   key_ff, key_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   ste_pkg::status_type     status_ff, status_in;
   logic                    found_ff, found_in;
   logic [CNT_BITS-1:0]     total_ff;
   logic                    empty_ff, full_ff;
   logic                    accept, apply, table_full;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && !busy_ff;
   // the update waits until the output slot is free
   assign apply      = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign table_full = count_ff == CNT_BITS'(CAPACITY);

   always_comb begin
      op_in  = op_ff;
      key_in = key_ff;
      if (accept) begin
         op_in  = ste_pkg::op_type'(req_opcode);
         key_in = req_value;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (apply) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = ste_pkg::ST_DONE;
      found_in  = 1'b0;
      case (op_ff)
         ste_pkg::OP_INSERT: begin
            if (table_full) begin
               status_in = ste_pkg::ST_FULL;
            end else begin
               count_in = count_ff + CNT_BITS'(1);
            end
         end
         ste_pkg::OP_DELETE: begin
            if (hit) begin
               count_in = count_ff - CNT_BITS'(1);
            end else begin
               status_in = ste_pkg::ST_NOT_FOUND;
            end
         end
         ste_pkg::OP_LOOKUP: begin
            found_in = hit;
         end
         ste_pkg::OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (apply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      cmd.capture = accept;
      cmd.insert  = apply && (op_ff == ste_pkg::OP_INSERT) && !table_full;
      cmd.remove  = apply && (op_ff == ste_pkg::OP_DELETE) && hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (apply) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      key_ff <= key_in;
      if (apply) begin
         status_ff <= status_in;
         found_ff  <= found_in;
         total_ff  <= count_in;
         empty_ff  <= count_in == '0;
         full_ff   <= count_in == CNT_BITS'(CAPACITY);
      end
   end

   assign key        = key_ff;
   assign count      = count_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_found  = found_ff;
   assign rsp_total  = total_ff;
   assign rsp_empty  = empty_ff;
   assign rsp_full   = full_ff;

   `STE_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_BITS'(CAPACITY))
   `STE_ASSERT_NOW(a_no_hit_empty, clock, reset, busy_ff && (count_ff == '0), !hit)
   `STE_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy_ff)
   `STE_ASSERT_NEXT(a_apply_rsp, clock, reset, apply, rsp_valid_ff)
   `STE_ASSERT_NEXT(a_idle_count, clock, reset, !busy_ff, $stable(count_ff))

endmodule
